// ===== design/bqlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bqlpf_pkg
// Shared widths, constants, register indexes and the microcode table of the
// biquad low-pass filter.
// ----------------------------------------------------------------------------
package bqlpf_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = 22;               // Q2.22, must not exceed HALF_W
    localparam int SCALE_W    = 32;
    localparam int SCALE_HALF = 16;
    localparam int LIMIT_W    = 31;
    localparam int DELAY_W    = 48;
    localparam int DELAY_FRAC = 16;
    localparam int HALF_W     = 24;               // split point of a delay word
    localparam int MUL_W      = HALF_W + 1;       // signed multiplier operand
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 52;
    localparam int RS_W       = ACC_W - DELAY_FRAC;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PC_W       = 5;

    // Register reset values
    localparam logic signed [COEF_W-1:0] B0_RESET =
        {2'b01, {(COEF_W-2){1'b0}}};                   // 1.0 in Q2.22
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000);

    // Saturation bounds and rounding constant
    localparam logic signed [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
    localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-DELAY_FRAC){1'b0}}, 1'b1, {(DELAY_FRAC-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2, CFG_SCALE, CFG_LIMIT
    } t_cfg_idx;

    // Multiplier operand A: sample, or one half of a delay word
    typedef enum logic [2:0] {
        OPA_SAMPLE, OPA_D1_LO, OPA_D1_HI, OPA_D2_LO, OPA_D2_HI, OPA_W_LO, OPA_W_HI
    } t_opa;

    // Multiplier operand B: a coefficient, or one half of the priming scale
    typedef enum logic [2:0] {
        OPB_B0, OPB_B1, OPB_B2, OPB_A1, OPB_A2, OPB_SCALE_LO, OPB_SCALE_HI
    } t_opb;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD_XQ, ACC_LOAD_TERM, ACC_ADD_TERM, ACC_SUB_TERM
    } t_acc_op;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_SKIP_IF_FILTER, SEQ_END
    } t_seq;

    // One control word
    typedef struct packed {
        t_opa             opa;
        t_opb             opb;
        logic             lo_cap;      // keep low partial product
        logic             prime_mode;  // scale-split alignment instead of Q2.22
        t_acc_op          acc_op;
        logic             prime_load;  // load both delays from primed value
        logic             w_cap;       // saturate accumulator into w
        t_seq             seq;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_PRIME  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_FILTER = PC_W'(4);
    localparam logic [PC_W-1:0] PC_LAST   = PC_W'(17);

    // Microcode ROM
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw.opa        = OPA_SAMPLE;
        uw.opb        = OPB_B0;
        uw.lo_cap     = 1'b0;
        uw.prime_mode = 1'b0;
        uw.acc_op     = ACC_HOLD;
        uw.prime_load = 1'b0;
        uw.w_cap      = 1'b0;
        uw.seq        = SEQ_NEXT;
        uw.target     = PC_FILTER;
        unique case (pc)
            // priming: p = x*scale_hi*2^16 + x*scale_lo
            5'd0: begin
                uw.opb = OPB_SCALE_LO;
                uw.seq = SEQ_SKIP_IF_FILTER;
            end
            5'd1: begin
                uw.opb        = OPB_SCALE_HI;
                uw.lo_cap     = 1'b1;
                uw.prime_mode = 1'b1;
            end
            5'd2: begin
                uw.acc_op     = ACC_LOAD_TERM;
                uw.prime_mode = 1'b1;
            end
            5'd3: uw.prime_load = 1'b1;
            // w = xq - d1*a1 - d2*a2
            5'd4: begin
                uw.opa    = OPA_D1_LO;
                uw.opb    = OPB_A1;
                uw.acc_op = ACC_LOAD_XQ;
            end
            5'd5: begin
                uw.opa    = OPA_D1_HI;
                uw.opb    = OPB_A1;
                uw.lo_cap = 1'b1;
            end
            5'd6: begin
                uw.opa    = OPA_D2_LO;
                uw.opb    = OPB_A2;
                uw.acc_op = ACC_SUB_TERM;
            end
            5'd7: begin
                uw.opa    = OPA_D2_HI;
                uw.opb    = OPB_A2;
                uw.lo_cap = 1'b1;
            end
            5'd8: uw.acc_op = ACC_SUB_TERM;
            5'd9: uw.w_cap  = 1'b1;
            // y = w*b0 + d1*b1 + d2*b2
            5'd10: begin
                uw.opa = OPA_W_LO;
                uw.opb = OPB_B0;
            end
            5'd11: begin
                uw.opa    = OPA_W_HI;
                uw.opb    = OPB_B0;
                uw.lo_cap = 1'b1;
            end
            5'd12: begin
                uw.opa    = OPA_D1_LO;
                uw.opb    = OPB_B1;
                uw.acc_op = ACC_LOAD_TERM;
            end
            5'd13: begin
                uw.opa    = OPA_D1_HI;
                uw.opb    = OPB_B1;
                uw.lo_cap = 1'b1;
            end
            5'd14: begin
                uw.opa    = OPA_D2_LO;
                uw.opb    = OPB_B2;
                uw.acc_op = ACC_ADD_TERM;
            end
            5'd15: begin
                uw.opa    = OPA_D2_HI;
                uw.opb    = OPB_B2;
                uw.lo_cap = 1'b1;
            end
            5'd16: uw.acc_op = ACC_ADD_TERM;
            default: uw.seq = SEQ_END;          // last step, and unused codes
        endcase
        return uw;
    endfunction

endpackage

// ===== design/bqlpf_datapath.sv =====
// ----------------------------------------------------------------------------
// bqlpf_datapath
// Configuration registers, delay elements, one shared 25x25 multiplier,
// partial-product recombination and the accumulator.
// ----------------------------------------------------------------------------
module bqlpf_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  bqlpf_pkg::t_uword                         i_uw,
    input  logic                                      i_load,
    input  logic signed [bqlpf_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                                      i_commit,
    input  logic                                      i_cfg_we,
    input  logic [bqlpf_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [bqlpf_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    output logic signed [bqlpf_pkg::SAMPLE_W-1:0]     o_y
);

    logic signed [bqlpf_pkg::SAMPLE_W-1:0] r_x;
    logic signed [bqlpf_pkg::COEF_W-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [bqlpf_pkg::SCALE_W-1:0]         r_scale;
    logic [bqlpf_pkg::LIMIT_W-1:0]         r_limit;
    logic signed [bqlpf_pkg::DELAY_W-1:0]  r_d1, r_d2, r_w;
    logic signed [bqlpf_pkg::PROD_W-1:0]   r_mul, r_lo;
    logic signed [bqlpf_pkg::ACC_W-1:0]    r_acc;

    logic signed [bqlpf_pkg::MUL_W-1:0]    opa, opb;
    logic signed [bqlpf_pkg::PROD_W-1:0]   n_mul;
    logic signed [bqlpf_pkg::ACC_W-1:0]    mul_ext, lo_ext, term, xq, n_acc, rnd;
    logic [bqlpf_pkg::ACC_W-1:0]           mag, lim_q;
    logic signed [bqlpf_pkg::DELAY_W-1:0]  w_sat;
    logic signed [bqlpf_pkg::RS_W-1:0]     rs;

    // operand A: sample, or a delay word split into unsigned low / signed high half
    always_comb begin
        unique case (i_uw.opa)
            bqlpf_pkg::OPA_SAMPLE:
                opa = {{(bqlpf_pkg::MUL_W-bqlpf_pkg::SAMPLE_W){r_x[bqlpf_pkg::SAMPLE_W-1]}},
                       r_x};
            bqlpf_pkg::OPA_D1_LO: opa = {1'b0, r_d1[bqlpf_pkg::HALF_W-1:0]};
            bqlpf_pkg::OPA_D1_HI:
                opa = {r_d1[bqlpf_pkg::DELAY_W-1], r_d1[bqlpf_pkg::DELAY_W-1:bqlpf_pkg::HALF_W]};
            bqlpf_pkg::OPA_D2_LO: opa = {1'b0, r_d2[bqlpf_pkg::HALF_W-1:0]};
            bqlpf_pkg::OPA_D2_HI:
                opa = {r_d2[bqlpf_pkg::DELAY_W-1], r_d2[bqlpf_pkg::DELAY_W-1:bqlpf_pkg::HALF_W]};
            bqlpf_pkg::OPA_W_LO:  opa = {1'b0, r_w[bqlpf_pkg::HALF_W-1:0]};
            bqlpf_pkg::OPA_W_HI:
                opa = {r_w[bqlpf_pkg::DELAY_W-1], r_w[bqlpf_pkg::DELAY_W-1:bqlpf_pkg::HALF_W]};
            default: opa = '0;
        endcase
    end

    always_comb begin
        unique case (i_uw.opb)
            bqlpf_pkg::OPB_B0: opb = {r_b0[bqlpf_pkg::COEF_W-1], r_b0};
            bqlpf_pkg::OPB_B1: opb = {r_b1[bqlpf_pkg::COEF_W-1], r_b1};
            bqlpf_pkg::OPB_B2: opb = {r_b2[bqlpf_pkg::COEF_W-1], r_b2};
            bqlpf_pkg::OPB_A1: opb = {r_a1[bqlpf_pkg::COEF_W-1], r_a1};
            bqlpf_pkg::OPB_A2: opb = {r_a2[bqlpf_pkg::COEF_W-1], r_a2};
            bqlpf_pkg::OPB_SCALE_LO:
                opb = {{(bqlpf_pkg::MUL_W-bqlpf_pkg::SCALE_HALF){1'b0}},
                       r_scale[bqlpf_pkg::SCALE_HALF-1:0]};
            bqlpf_pkg::OPB_SCALE_HI:
                opb = {{(bqlpf_pkg::MUL_W-bqlpf_pkg::SCALE_HALF){1'b0}},
                       r_scale[bqlpf_pkg::SCALE_W-1:bqlpf_pkg::SCALE_HALF]};
            default: opb = '0;
        endcase
    end

    assign n_mul   = opa * opb;
    assign mul_ext = {{(bqlpf_pkg::ACC_W-bqlpf_pkg::PROD_W){r_mul[bqlpf_pkg::PROD_W-1]}}, r_mul};
    assign lo_ext  = {{(bqlpf_pkg::ACC_W-bqlpf_pkg::PROD_W){r_lo[bqlpf_pkg::PROD_W-1]}}, r_lo};

    // floor(hi*2^24 + lo) / 2^22 == hi*4 + floor(lo / 2^22); r_lo already shifted
    assign term = i_uw.prime_mode ? (mul_ext <<< bqlpf_pkg::SCALE_HALF) + lo_ext
                : (mul_ext <<< (bqlpf_pkg::HALF_W - bqlpf_pkg::COEF_FRAC)) + lo_ext;

    assign xq = {{(bqlpf_pkg::ACC_W-bqlpf_pkg::SAMPLE_W-bqlpf_pkg::DELAY_FRAC)
                  {r_x[bqlpf_pkg::SAMPLE_W-1]}}, r_x, {bqlpf_pkg::DELAY_FRAC{1'b0}}};

    always_comb begin
        unique case (i_uw.acc_op)
            bqlpf_pkg::ACC_HOLD:      n_acc = r_acc;
            bqlpf_pkg::ACC_LOAD_XQ:   n_acc = xq;
            bqlpf_pkg::ACC_LOAD_TERM: n_acc = term;
            bqlpf_pkg::ACC_ADD_TERM:  n_acc = r_acc + term;
            bqlpf_pkg::ACC_SUB_TERM:  n_acc = r_acc - term;
            default:                  n_acc = r_acc;
        endcase
    end

    // priming bound: |p| < limit in Q.16
    assign mag   = r_acc[bqlpf_pkg::ACC_W-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
    assign lim_q = {{(bqlpf_pkg::ACC_W-bqlpf_pkg::LIMIT_W-bqlpf_pkg::DELAY_FRAC){1'b0}},
                    r_limit, {bqlpf_pkg::DELAY_FRAC{1'b0}}};

    always_comb begin
        if ((&r_acc[bqlpf_pkg::ACC_W-1:bqlpf_pkg::DELAY_W-1]) ||
            !(|r_acc[bqlpf_pkg::ACC_W-1:bqlpf_pkg::DELAY_W-1])) begin
            w_sat = r_acc[bqlpf_pkg::DELAY_W-1:0];
        end else if (r_acc[bqlpf_pkg::ACC_W-1]) begin
            w_sat = bqlpf_pkg::DELAY_MIN;
        end else begin
            w_sat = bqlpf_pkg::DELAY_MAX;
        end
    end

    // output: round half up, then saturate
    assign rnd = r_acc + bqlpf_pkg::ROUND_HALF;
    assign rs  = rnd[bqlpf_pkg::ACC_W-1:bqlpf_pkg::DELAY_FRAC];

    always_comb begin
        if ((&rs[bqlpf_pkg::RS_W-1:bqlpf_pkg::SAMPLE_W-1]) ||
            !(|rs[bqlpf_pkg::RS_W-1:bqlpf_pkg::SAMPLE_W-1])) begin
            o_y = rs[bqlpf_pkg::SAMPLE_W-1:0];
        end else if (rs[bqlpf_pkg::RS_W-1]) begin
            o_y = bqlpf_pkg::SAMPLE_MIN;
        end else begin
            o_y = bqlpf_pkg::SAMPLE_MAX;
        end
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        r_mul <= n_mul;
        r_acc <= n_acc;
        if (i_load) begin
            r_x <= i_sample;
        end
        if (i_uw.lo_cap) begin
            r_lo <= i_uw.prime_mode ? r_mul : (r_mul >>> bqlpf_pkg::COEF_FRAC);
        end
        if (i_uw.w_cap) begin
            r_w <= w_sat;
        end
    end

    // delay elements
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_uw.prime_load) begin
            if (mag < lim_q) begin
                r_d1 <= r_acc[bqlpf_pkg::DELAY_W-1:0];
                r_d2 <= r_acc[bqlpf_pkg::DELAY_W-1:0];
            end else begin
                r_d1 <= xq[bqlpf_pkg::DELAY_W-1:0];
                r_d2 <= xq[bqlpf_pkg::DELAY_W-1:0];
            end
        end else if (i_commit) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= bqlpf_pkg::B0_RESET;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_scale <= bqlpf_pkg::SCALE_RESET;
            r_limit <= bqlpf_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (bqlpf_pkg::t_cfg_idx'(i_cfg_idx))
                bqlpf_pkg::CFG_B0:    r_b0    <= i_cfg_data[bqlpf_pkg::COEF_W-1:0];
                bqlpf_pkg::CFG_B1:    r_b1    <= i_cfg_data[bqlpf_pkg::COEF_W-1:0];
                bqlpf_pkg::CFG_B2:    r_b2    <= i_cfg_data[bqlpf_pkg::COEF_W-1:0];
                bqlpf_pkg::CFG_A1:    r_a1    <= i_cfg_data[bqlpf_pkg::COEF_W-1:0];
                bqlpf_pkg::CFG_A2:    r_a2    <= i_cfg_data[bqlpf_pkg::COEF_W-1:0];
                bqlpf_pkg::CFG_SCALE: r_scale <= i_cfg_data[bqlpf_pkg::SCALE_W-1:0];
                bqlpf_pkg::CFG_LIMIT: r_limit <= i_cfg_data[bqlpf_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/biquad_lowpass_filter.sv =====
// Work on a sample runs through the filter steps, after the priming steps for a prime.
// One transaction at a time: the ten partial products (twelve when priming) share the
//   one 25x25 multiplier, and no new sample is taken until the result is registered.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low) restores pass-through coefficients, clears both
//   delay elements and drops any result not yet taken.
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct Form II biquad on signed 16-bit samples, driven by a microcoded
// sequencer over a single shared multiplier and accumulator.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_cmd,
    input  logic signed [bqlpf_pkg::SAMPLE_W-1:0]   i_sample,
    // output channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [bqlpf_pkg::SAMPLE_W-1:0]   o_filtered,
    // configuration write port
    input  logic                                    i_cfg_we,
    input  logic [bqlpf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [bqlpf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // Sequencer state. Idle parks the step counter on the last step, whose
    // control word does nothing in the datapath.
    logic                          r_busy, n_busy;
    logic [bqlpf_pkg::PC_W-1:0]    r_pc, n_pc;
    logic                          r_cmd;
    logic                          r_out_valid;
    logic signed [bqlpf_pkg::SAMPLE_W-1:0] r_out;

    bqlpf_pkg::t_uword             uw;
    logic                          in_take;
    logic                          out_free;
    logic                          commit;
    logic signed [bqlpf_pkg::SAMPLE_W-1:0] y;

    // one transaction at a time; stall also held through reset
    assign o_in_stall = r_busy || !i_rst_n;
    assign in_take    = i_in_valid && !o_in_stall;

    // output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // control word for the current step
    assign uw = bqlpf_pkg::ucode(r_pc);

    // Step counter: straight-line program with one conditional skip over
    // the priming steps, and a final step that waits for the output slot.
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        commit = 1'b0;
        if (!r_busy) begin
            if (in_take) begin
                n_busy = 1'b1;
                n_pc   = bqlpf_pkg::PC_PRIME;
            end
        end else begin
            unique case (uw.seq)
                bqlpf_pkg::SEQ_NEXT: n_pc = r_pc + bqlpf_pkg::PC_W'(1);
                bqlpf_pkg::SEQ_SKIP_IF_FILTER:
                    n_pc = r_cmd ? r_pc + bqlpf_pkg::PC_W'(1) : uw.target;
                bqlpf_pkg::SEQ_END: begin
                    if (out_free) begin
                        commit = 1'b1;     // delays advance, result registered
                        n_busy = 1'b0;
                    end
                end
                default: n_pc = bqlpf_pkg::PC_LAST;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= bqlpf_pkg::PC_LAST;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

    bqlpf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uw       (uw),
        .i_load     (in_take),
        .i_sample   (i_sample),
        .i_commit   (commit),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_y        (y)
    );

endmodule

// ===== design/bqlpf_checker.sv =====
// ----------------------------------------------------------------------------
// bqlpf_checker
// Port-level checks on the biquad filter's transaction timing.
// ----------------------------------------------------------------------------
module bqlpf_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    o_in_stall,
    input  logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [bqlpf_pkg::SAMPLE_W-1:0]   o_filtered
);

    // busy right after taking a sample
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transaction");

    // a result only appears at the end of work on a sample
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in flight");

    // no result can be produced in the cycle a sample is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result produced too early");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_filtered)))
        else $error("stalled result changed");

endmodule

bind biquad_lowpass_filter bqlpf_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_filtered  (o_filtered)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the biquad low-pass filter. A bit-accurate
// predictor of the Direct Form II datapath (priming, Q2.22 products, delay
// and output saturation, round-half-up) works out each filtered sample.
// Every result transaction is compared with the oldest prediction. A short
// directed table runs first, then randomised phases, each with its own
// coefficient set, random idling on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
    import bqlpf_pkg::*;

    typedef enum logic {CMD_FILTER = 1'b0, CMD_PRIME = 1'b1} sample_cmd_e;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {STYLE_BUTTER, STYLE_SMALL, STYLE_WIDE, STYLE_EXTREME} coef_style_e;

    // Index past the register list: the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int IDLE_LIMIT    = 1000;    // cycles with no transaction at all
    localparam int DRAIN_CYCLES  = 40;      // extra idle wait after the final drain
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 55;

    // One row of the directed table: either a register write or a sample
    typedef struct packed {
        row_kind_e                    kind;
        logic [CFG_IDX_W-1:0]         idx;
        logic [CFG_DATA_W-1:0]        data;
        sample_cmd_e                  cmd;
        logic signed [SAMPLE_W-1:0]   smp;
        logic                         known;    // want is typed in, not predicted
        logic signed [SAMPLE_W-1:0]   want;
    } stim_row_t;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic                           i_cmd;
    logic signed [SAMPLE_W-1:0]     i_sample;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]     o_filtered;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [CFG_DATA_W-1:0]          i_cfg_data;

    // Shadow copy of the registers and delay elements
    logic signed [COEF_W-1:0]       b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [SCALE_W-1:0]             scale_reg;
    logic [LIMIT_W-1:0]             limit_reg;
    logic signed [DELAY_W-1:0]      delay1, delay2;

    logic signed [SAMPLE_W-1:0]     filtered_due[$];
    int                             mismatch_count = 0;
    int                             idle_cycles = 0;
    int                             tx_gap_max = 4;
    int                             rx_gap_max = 4;
    int                             stall_left = 0;

    // Directed table. Pass-through first, then output saturation, rounding
    // ties, the priming bound on both sides, and delay saturation.
    stim_row_t dir_rows[$] = '{
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd0,     1'b1, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd32767, 1'b1, 16'sd32767},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sh8000,  1'b1, 16'sh8000},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, -16'sd1,    1'b1, -16'sd1},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  16'sd12345, 1'b1, 16'sd12345},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  16'sh8000,  1'b1, 16'sh8000},
        '{ROW_CFG,  CFG_UNUSED, 32'hFFFF_FFFF, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd1,     1'b1, 16'sd1},
        // b0 = -2.0, upper data bits set on purpose
        '{ROW_CFG,  CFG_B0,     32'hFF80_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd32767, 1'b1, 16'sh8000},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sh8000,  1'b1, 16'sd32767},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd3,     1'b1, -16'sd6},
        // b0 = 0.5: halves land on ties, which round upwards
        '{ROW_CFG,  CFG_B0,     32'h0020_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd1,     1'b1, 16'sd1},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, -16'sd1,    1'b1, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, -16'sd3,    1'b1, -16'sd1},
        '{ROW_CFG,  CFG_B0,     32'h007F_FFFF, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sh8000,  1'b0, 16'sd0},
        // y = w + d1, priming scale 2.0, bound of one sample unit
        '{ROW_CFG,  CFG_B0,     32'h0040_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_B1,     32'h0040_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_SCALE,  32'h0002_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_LIMIT,  32'd1,         CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  16'sd1,     1'b1, 16'sd2},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  16'sd0,     1'b1, 16'sd0},
        '{ROW_CFG,  CFG_LIMIT,  32'h7FFF_FFFF, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  -16'sd3,    1'b0, 16'sd0},
        '{ROW_CFG,  CFG_LIMIT,  32'd0,         CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  -16'sd3,    1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd5,     1'b0, 16'sd0},
        // a1 = a2 = -2.0 with a huge primed value: w runs into its clamp
        '{ROW_CFG,  CFG_A1,     32'h0080_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_A2,     32'h0080_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_SCALE,  32'hFFFF_FFFF, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_LIMIT,  32'h7FFF_FFFF, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_B1,     32'h007F_FFFF, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_PRIME,  16'sd32767, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sh8000,  1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd32767, 1'b0, 16'sd0},
        '{ROW_CFG,  CFG_B2,     32'h0080_0000, CMD_FILTER, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sd0,     1'b0, 16'sd0},
        '{ROW_ITEM, CFG_UNUSED, 32'd0, CMD_FILTER, 16'sh8000,  1'b0, 16'sd0}
    };

    biquad_lowpass_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // floor(d * c / 2^COEF_FRAC), exact product before the shift
    function automatic logic signed [63:0] coef_product(input logic signed [DELAY_W-1:0] d,
                                                         input logic signed [COEF_W-1:0] c);
        logic signed [DELAY_W+COEF_W-1:0] prod;
        prod = d * c;
        return 64'(prod >>> COEF_FRAC);
    endfunction

    // Advances the shadow delays by one sample and returns the filtered value
    function automatic logic signed [SAMPLE_W-1:0] predict_filtered(
            input sample_cmd_e cmd, input logic signed [SAMPLE_W-1:0] x);
        logic signed [63:0]         xq, p, mag, w, y;
        logic signed [DELAY_W-1:0]  w_sat;
        xq = 64'(x);
        xq = xq <<< DELAY_FRAC;
        if (cmd == CMD_PRIME) begin
            p   = x * $signed({1'b0, scale_reg});
            mag = (p < 0) ? -p : p;
            // primed value only if strictly inside the bound, else the raw sample
            if (mag < ({33'd0, limit_reg} << DELAY_FRAC)) begin
                delay1 = p[DELAY_W-1:0];
                delay2 = p[DELAY_W-1:0];
            end else begin
                delay1 = xq[DELAY_W-1:0];
                delay2 = xq[DELAY_W-1:0];
            end
        end
        w = xq - coef_product(delay1, a1_reg) - coef_product(delay2, a2_reg);
        if (w > DELAY_MAX) begin
            w = 64'(DELAY_MAX);
        end else if (w < DELAY_MIN) begin
            w = 64'(DELAY_MIN);
        end
        w_sat = w[DELAY_W-1:0];
        y = coef_product(w_sat, b0_reg) + coef_product(delay1, b1_reg)
            + coef_product(delay2, b2_reg);
        delay2 = delay1;
        delay1 = w_sat;
        y = (y + (64'sd1 <<< (DELAY_FRAC - 1))) >>> DELAY_FRAC;
        if (y > SAMPLE_MAX) begin
            y = 64'(SAMPLE_MAX);
        end else if (y < SAMPLE_MIN) begin
            y = 64'(SAMPLE_MIN);
        end
        return y[SAMPLE_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_B0:    b0_reg    = data[COEF_W-1:0];
            CFG_B1:    b1_reg    = data[COEF_W-1:0];
            CFG_B2:    b2_reg    = data[COEF_W-1:0];
            CFG_A1:    a1_reg    = data[COEF_W-1:0];
            CFG_A2:    a2_reg    = data[COEF_W-1:0];
            CFG_SCALE: scale_reg = data[SCALE_W-1:0];
            CFG_LIMIT: limit_reg = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // One input transaction with a random lead-in gap. Valid stays high
    // across back-to-back transactions; the payload holds while stalled.
    task automatic send_sample(input sample_cmd_e cmd, input logic signed [SAMPLE_W-1:0] smp,
                               input logic known, input logic signed [SAMPLE_W-1:0] want);
        int                         gap;
        logic signed [SAMPLE_W-1:0] due;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd      = cmd;
        i_sample   = smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // accepted at this edge: the shadow state moves on regardless
        due = predict_filtered(cmd, smp);
        filtered_due.push_back(known ? want : due);
        @(negedge i_clk);
    endtask

    // Block is idle once every result is back: one result per sample
    task automatic wait_drained;
        i_in_valid = 1'b0;
        while (filtered_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Result checker: compares every output transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: filtered expected none, actual %0d", $time, o_filtered);
            end else begin
                want = filtered_due.pop_front();
                if (o_filtered !== want) begin
                    mismatch_count++;
                    $display("%0t: filtered expected %0d, actual %0d",
                             $time, want, o_filtered);
                end
            end
            stall_left = $urandom_range(0, rx_gap_max);
        end
    end

    // Output stall: raised ahead of the next result too, and counted down
    // only while a result is actually waiting.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            if (o_out_valid)
                stall_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Watchdog on cycles with neither an input nor an output transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int                         phase, k, n;
        stim_row_t                  row;
        int                         coef[5];
        logic [CFG_DATA_W-1:0]      scale_val, limit_val;
        coef_style_e                style;
        sample_cmd_e                cmd;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         narrow;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = CMD_FILTER;
        i_sample   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;

        // shadow state after reset: pass-through
        b0_reg    = B0_RESET;
        b1_reg    = '0;
        b2_reg    = '0;
        a1_reg    = '0;
        a2_reg    = '0;
        scale_reg = SCALE_RESET;
        limit_reg = LIMIT_RESET;
        delay1    = '0;
        delay2    = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_reg(row.idx, row.data);
            end else begin
                send_sample(row.cmd, row.smp, row.known, row.want);
            end
        end

        // Random phases, each with its own coefficient style and idling mix
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            style = coef_style_e'(phase % 4);
            if (style == STYLE_BUTTER) begin
                // designed low-pass sections at fc/fs of 0.02 and 0.1
                narrow    = 1'($urandom_range(0, 1));
                coef[0]   = narrow ? 15190 : 282924;
                coef[1]   = narrow ? 30380 : 565848;
                coef[2]   = coef[0];
                coef[3]   = narrow ? -7644930 : -4794000;
                coef[4]   = narrow ? 3511390 : 1731400;
                scale_val = narrow ? 32'd4523800 : 32'd242860;
            end else begin
                for (k = 0; k < 5; k++) begin
                    case (style)
                        STYLE_SMALL: coef[k] = int'($urandom_range(0, 4194304)) - 2097152;
                        STYLE_WIDE:  coef[k] = int'($urandom());
                        default: begin
                            case ($urandom_range(0, 3))
                                0:       coef[k] = -8388608;
                                1:       coef[k] = 8388607;
                                2:       coef[k] = 0;
                                default: coef[k] = int'($urandom());
                            endcase
                        end
                    endcase
                end
                case ($urandom_range(0, 3))
                    0:       scale_val = '0;
                    1:       scale_val = 32'hFFFF_FFFF;
                    2:       scale_val = $urandom_range(0, 262144);
                    default: scale_val = $urandom();
                endcase
            end
            case ($urandom_range(0, 4))
                0:       limit_val = '0;
                1:       limit_val = 32'd1;
                2:       limit_val = 32'h7FFF_FFFF;
                3:       limit_val = $urandom_range(0, 40000);
                default: limit_val = 32'd100000;
            endcase
            write_reg(CFG_B0, CFG_DATA_W'(coef[0]));
            write_reg(CFG_B1, CFG_DATA_W'(coef[1]));
            write_reg(CFG_B2, CFG_DATA_W'(coef[2]));
            write_reg(CFG_A1, CFG_DATA_W'(coef[3]));
            write_reg(CFG_A2, CFG_DATA_W'(coef[4]));
            write_reg(CFG_SCALE, scale_val);
            write_reg(CFG_LIMIT, limit_val);
            if ($urandom_range(0, 1))
                write_reg(CFG_UNUSED, $urandom());

            // either side may run flat out for a whole phase
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // each phase opens with a prime, as a sensor start-up would
                cmd = (n == 0 || $urandom_range(0, 7) == 0) ? CMD_PRIME : CMD_FILTER;
                case ($urandom_range(0, 7))
                    0:       smp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                    1:       smp = SAMPLE_W'($urandom_range(0, 128)) - SAMPLE_W'(64);
                    default: smp = SAMPLE_W'($urandom());
                endcase
                send_sample(cmd, smp, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && filtered_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bqlpf_pkg.sv
design/bqlpf_datapath.sv
design/biquad_lowpass_filter.sv
design/bqlpf_checker.sv
tb/tb.sv
